// ----- rtl/rgb2hsl_pkg.sv -----
// Shared types and constants for the RGB to HSL converter.
// Holds the pixel and result beat layouts and the fixed-point scaling.
// No dependencies.
package rgb2hsl_pkg;

   // Channel width; full scale is 2^CHAN_W - 1
   localparam int CHAN_W     = 8;
   localparam int FULL_SCALE = (1 << CHAN_W) - 1;

   // Saturation and lightness are Q1.12, hue is degrees with 6 fraction bits
   localparam int FRAC_W     = 12;
   localparam int DEG60_Q6   = 60 * 64;
   localparam int DEG360_Q6  = 360 * 64;
   localparam int DEG60_W    = $clog2(DEG60_Q6 + 1);

   // Quotient widths
   localparam int HUE_Q      = 15;
   localparam int LEVEL_Q    = 13;

   // Internal widths
   localparam int SUM_W       = CHAN_W + 1;
   localparam int TERM_W      = CHAN_W + 3;
   localparam int HUE_NUM_W   = TERM_W + DEG60_W;
   localparam int SAT_NUM_W   = CHAN_W + FRAC_W;
   localparam int LIGHT_NUM_W = SUM_W + FRAC_W;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic [HUE_Q-1:0]   hue_deg;
      logic [LEVEL_Q-1:0] sat_level;
      logic [LEVEL_Q-1:0] light_level;
      logic               achromatic;
   } hsl_type;

endpackage

// ----- rtl/rgb_to_hsl.sv -----
// RGB to HSL converter, fully pipelined.
// The strobe follows the pixel, sector, product and divider-load registers, then the divide stages.
// Throughput: one pixel per clock; busy stays low. Each of the 15 restoring
// divide stages gives one hue quotient bit; only the low ones also give saturation and lightness bits.
// Reset clears only the valid bits; results leave on rsp_strobe unstalled.
// Depends on rgb2hsl_pkg.
module rgb_to_hsl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rgb2hsl_pkg::pixel_type req_data,
   output logic                  rsp_strobe,
   output rgb2hsl_pkg::hsl_type   rsp_data
);

   localparam int CHAN_W      = rgb2hsl_pkg::CHAN_W;
   localparam int SUM_W       = rgb2hsl_pkg::SUM_W;
   localparam int TERM_W      = rgb2hsl_pkg::TERM_W;
   localparam int HUE_NUM_W   = rgb2hsl_pkg::HUE_NUM_W;
   localparam int SAT_NUM_W   = rgb2hsl_pkg::SAT_NUM_W;
   localparam int LIGHT_NUM_W = rgb2hsl_pkg::LIGHT_NUM_W;
   localparam int HUE_Q       = rgb2hsl_pkg::HUE_Q;
   localparam int LEVEL_Q     = rgb2hsl_pkg::LEVEL_Q;
   localparam int FRAC_W      = rgb2hsl_pkg::FRAC_W;

   typedef struct packed {
      logic              gray;
      logic [CHAN_W-1:0] diff;
      logic [SUM_W-1:0]  sum;
      logic [TERM_W-1:0] term;
   } sect_type;

   typedef struct packed {
      logic                 gray;
      logic [CHAN_W-1:0]    diff;
      logic [CHAN_W-1:0]    sat_den;
      logic [SUM_W-1:0]     sum;
      logic [HUE_NUM_W-1:0] hue_num;
      logic [HUE_NUM_W-1:0] hue_lim;
   } prod_type;

   typedef struct packed {
      logic                   gray;
      logic [HUE_NUM_W-1:0]   hue_rem;
      logic [CHAN_W-1:0]      hue_div;
      logic [HUE_Q-1:0]       hue_q;
      logic [SAT_NUM_W-1:0]   sat_rem;
      logic [CHAN_W-1:0]      sat_div;
      logic [LEVEL_Q-1:0]     sat_q;
      logic [LIGHT_NUM_W-1:0] light_rem;
      logic [LEVEL_Q-1:0]     light_q;
   } div_stage_type;

   // Valid bits, one per stage
   logic              pix_valid_ff;
   logic              sect_valid_ff;
   logic              prod_valid_ff;
   logic [HUE_Q:0]    dv_valid_ff;

   rgb2hsl_pkg::pixel_type pix_ff;
   sect_type               sect_in, sect_ff;
   prod_type               prod_in, prod_ff;
   div_stage_type          dv0_in;
   div_stage_type          dv_in [1:HUE_Q];
   div_stage_type          dv_ff [0:HUE_Q];

   logic [CHAN_W-1:0] mx, mn;

   logic [HUE_NUM_W-1:0]   hue_sub;
   logic [SAT_NUM_W-1:0]   sat_sub;
   logic [LIGHT_NUM_W-1:0] light_sub;

   assign busy = 1'b0;

   // Stage 1: extremes, sector term
   always_comb begin
      logic [CHAN_W-1:0] r, g, b;
      r = pix_ff.red_in;
      g = pix_ff.green_in;
      b = pix_ff.blue_in;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sect_in.gray = (mx == mn);
      sect_in.diff = mx - mn;
      sect_in.sum  = SUM_W'(mx) + SUM_W'(mn);
      // blue wins a tied max, then green
      priority if (b == mx) begin
         sect_in.term = (TERM_W'(sect_in.diff) << 2) + TERM_W'(r) - TERM_W'(g);
      end else if (g == mx) begin
         sect_in.term = (TERM_W'(sect_in.diff) << 1) + TERM_W'(b) - TERM_W'(r);
      end else begin
         sect_in.term = (TERM_W'(sect_in.diff) << 2) + (TERM_W'(sect_in.diff) << 1)
                      + TERM_W'(g) - TERM_W'(b);
      end
   end

   // Stage 2: scale hue numerator, wrap limit, fold saturation denominator
   always_comb begin
      prod_in.gray    = sect_ff.gray;
      prod_in.diff    = sect_ff.diff;
      prod_in.sum     = sect_ff.sum;
      prod_in.hue_num = HUE_NUM_W'(sect_ff.term) * HUE_NUM_W'(rgb2hsl_pkg::DEG60_Q6);
      prod_in.hue_lim = HUE_NUM_W'(sect_ff.diff) * HUE_NUM_W'(rgb2hsl_pkg::DEG360_Q6);
      if (sect_ff.sum > SUM_W'(rgb2hsl_pkg::FULL_SCALE)) begin
         prod_in.sat_den = CHAN_W'(SUM_W'(2 * rgb2hsl_pkg::FULL_SCALE) - sect_ff.sum);
      end else begin
         prod_in.sat_den = CHAN_W'(sect_ff.sum);
      end
   end

   // Stage 3: wrap above 360 degrees, load the divider
   always_comb begin
      dv0_in.gray = prod_ff.gray;
      if (prod_ff.hue_num > prod_ff.hue_lim) begin
         dv0_in.hue_rem = prod_ff.hue_num - prod_ff.hue_lim;
      end else begin
         dv0_in.hue_rem = prod_ff.hue_num;
      end
      dv0_in.hue_div   = prod_ff.diff;
      dv0_in.hue_q     = '0;
      dv0_in.sat_rem   = SAT_NUM_W'(prod_ff.diff) << FRAC_W;
      dv0_in.sat_div   = prod_ff.sat_den;
      dv0_in.sat_q     = '0;
      dv0_in.light_rem = LIGHT_NUM_W'(prod_ff.sum) << FRAC_W;
      dv0_in.light_q   = '0;
   end

   // Restoring divide, one quotient bit per stage, MSB first
   always_comb begin
      hue_sub   = '0;
      sat_sub   = '0;
      light_sub = '0;
      for (int j = 0; j < HUE_Q; j++) begin
         dv_in[j+1] = dv_ff[j];
         hue_sub = HUE_NUM_W'(dv_ff[j].hue_div) << (HUE_Q - 1 - j);
         if (dv_ff[j].hue_rem >= hue_sub) begin
            dv_in[j+1].hue_rem = dv_ff[j].hue_rem - hue_sub;
            dv_in[j+1].hue_q   = dv_ff[j].hue_q | (HUE_Q'(1) << (HUE_Q - 1 - j));
         end
         // level quotients are narrower: only the low stages do work
         if ((HUE_Q - 1 - j) < LEVEL_Q) begin
            sat_sub = SAT_NUM_W'(dv_ff[j].sat_div) << (HUE_Q - 1 - j);
            if (dv_ff[j].sat_rem >= sat_sub) begin
               dv_in[j+1].sat_rem = dv_ff[j].sat_rem - sat_sub;
               dv_in[j+1].sat_q   = dv_ff[j].sat_q | (LEVEL_Q'(1) << (HUE_Q - 1 - j));
            end
            light_sub = LIGHT_NUM_W'(2 * rgb2hsl_pkg::FULL_SCALE) << (HUE_Q - 1 - j);
            if (dv_ff[j].light_rem >= light_sub) begin
               dv_in[j+1].light_rem = dv_ff[j].light_rem - light_sub;
               dv_in[j+1].light_q   = dv_ff[j].light_q | (LEVEL_Q'(1) << (HUE_Q - 1 - j));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff  <= 1'b0;
         sect_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         dv_valid_ff   <= '0;
      end else begin
         pix_valid_ff  <= start & ~busy;
         sect_valid_ff <= pix_valid_ff;
         prod_valid_ff <= sect_valid_ff;
         dv_valid_ff   <= {dv_valid_ff[HUE_Q-1:0], prod_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= req_data;
      sect_ff  <= sect_in;
      prod_ff  <= prod_in;
      dv_ff[0] <= dv0_in;
      for (int j = 1; j <= HUE_Q; j++) begin
         dv_ff[j] <= dv_in[j];
      end
   end

   // Gray pixel: the hue divisor is zero (the saturation one at black and white), so force hue and saturation
   always_comb begin
      rsp_strobe           = dv_valid_ff[HUE_Q];
      rsp_data.achromatic  = dv_ff[HUE_Q].gray;
      rsp_data.light_level = dv_ff[HUE_Q].light_q;
      if (dv_ff[HUE_Q].gray) begin
         rsp_data.hue_deg   = '0;
         rsp_data.sat_level = '0;
      end else begin
         rsp_data.hue_deg   = dv_ff[HUE_Q].hue_q;
         rsp_data.sat_level = dv_ff[HUE_Q].sat_q;
      end
   end

endmodule

// ----- tb/sv/rgb_to_hsl_chk.sv -----
`timescale 1ns / 100ps
// Checker for rgb_to_hsl: predicts HSL for every pixel beat taken and compares
// each result beat against the oldest prediction. Depends on rgb2hsl_pkg.
module rgb_to_hsl_chk
   import rgb2hsl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      busy,
   input  pixel_type req_data,
   input  logic      rsp_strobe,
   input  hsl_type   rsp_data,
   output int        fail_count,
   output int        pending
);

   typedef enum logic [1:0] {PEAK_RED, PEAK_GREEN, PEAK_BLUE} peak_type;

   localparam int TOP_CODE     = (1 << CHAN_W) - 1;
   localparam int Q12_ONE      = 4096;
   localparam int SIXTY_Q6     = 60 * 64;
   localparam int FULL_TURN_Q6 = 360 * 64;

   hsl_type expected_hsl_q[$];
   int      result_beats = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic hsl_type predict_hsl(pixel_type px);
      int       r, g, b, hi, lo, d, s, num;
      peak_type peak;
      hsl_type  res;
      r  = px.red_in;
      g  = px.green_in;
      b  = px.blue_in;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      res = '0;
      res.light_level = LEVEL_Q'(((hi + lo) * Q12_ONE) / (2 * TOP_CODE));
      if (hi == lo) begin
         res.achromatic = 1'b1;
      end else begin
         d = hi - lo;
         s = hi + lo;
         // bright half folds the denominator back
         if (s > TOP_CODE) s = 2 * TOP_CODE - s;
         res.sat_level = LEVEL_Q'((d * Q12_ONE) / s);
         // ties on the max: blue beats green beats red
         if (b == hi) peak = PEAK_BLUE;
         else if (g == hi) peak = PEAK_GREEN;
         else peak = PEAK_RED;
         case (peak)
            PEAK_BLUE:  num = SIXTY_Q6 * (4 * d + r - g);
            PEAK_GREEN: num = SIXTY_Q6 * (2 * d + b - r);
            default:    num = SIXTY_Q6 * (6 * d + g - b);
         endcase
         // only strictly above a full turn wraps, so 360 degrees survives
         if (num > FULL_TURN_Q6 * d) num -= FULL_TURN_Q6 * d;
         res.hue_deg = HUE_Q'(num / d);
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ns rgb_to_hsl result beat %0d: %s", $time, result_beats, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      hsl_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_hsl_q.size() == 0) begin
               report_mismatch("result beat with no pixel outstanding");
            end else begin
               want = expected_hsl_q.pop_front();
               if (rsp_data.hue_deg !== want.hue_deg)
                  report_mismatch($sformatf("hue_deg got %0d expected %0d",
                                            rsp_data.hue_deg, want.hue_deg));
               if (rsp_data.sat_level !== want.sat_level)
                  report_mismatch($sformatf("sat_level got %0d expected %0d",
                                            rsp_data.sat_level, want.sat_level));
               if (rsp_data.light_level !== want.light_level)
                  report_mismatch($sformatf("light_level got %0d expected %0d",
                                            rsp_data.light_level, want.light_level));
               if (rsp_data.achromatic !== want.achromatic)
                  report_mismatch($sformatf("achromatic got %0b expected %0b",
                                            rsp_data.achromatic, want.achromatic));
            end
            result_beats++;
         end
         if (start && !busy)
            expected_hsl_q.push_back(predict_hsl(req_data));
      end
      pending <= expected_hsl_q.size();
   end

endmodule

// ----- tb/sv/rgb_to_hsl_tb.sv -----
`timescale 1ns / 100ps
// Top of the rgb_to_hsl testbench: clock, reset, pixel stimulus and verdict.
// Depends on rgb2hsl_pkg, rgb_to_hsl and the rgb_to_hsl_chk checker.
module rgb_to_hsl_tb;
   import rgb2hsl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_BEATS    = 212;

   logic      clock    = 1'b0;
   logic      reset    = 1'b1;
   logic      start    = 1'b0;
   pixel_type req_data = '0;
   logic      busy;
   logic      rsp_strobe;
   hsl_type   rsp_data;
   int        fail_count;
   int        pending;
   int        stall_cycles = 0;
   int        idle_pct     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb_to_hsl u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   rgb_to_hsl_chk u_chk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic pixel_type make_pixel(int r, int g, int b);
      pixel_type px;
      px.red_in   = CHAN_W'(r);
      px.green_in = CHAN_W'(g);
      px.blue_in  = CHAN_W'(b);
      return px;
   endfunction

   function automatic pixel_type rand_pixel();
      int r, g, b, hi, lo, kind;
      kind = $urandom_range(9);
      r    = $urandom_range(255);
      g    = $urandom_range(255);
      b    = $urandom_range(255);
      case (kind)
         5: begin
            g = r;
            b = r;
         end
         6: begin
            // two channels tied on the max
            hi = $urandom_range(255, 1);
            lo = $urandom_range(hi - 1);
            case ($urandom_range(2))
               0: begin r = hi; g = hi; b = lo; end
               1: begin r = lo; g = hi; b = hi; end
               default: begin r = hi; g = lo; b = hi; end
            endcase
         end
         7: begin
            // red max with green == blue lands on exactly 360
            g = $urandom_range(254);
            r = $urandom_range(255, g + 1);
            b = g;
         end
         8: begin
            r = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
            g = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
            b = $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1);
         end
         9: begin
            // at most one LSB away from gray
            g = r ^ $urandom_range(1);
            b = r ^ $urandom_range(1);
         end
         default: ;
      endcase
      return make_pixel(r, g, b);
   endfunction

   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= make_pixel($urandom_range(255), $urandom_range(255),
                                $urandom_range(255));
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every outstanding result beat has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic stream_pixels(int pct);
      idle_pct = pct;
      repeat (PHASE_BEATS) send_pixel(rand_pixel());
      drain_results();
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(255, 255, 255));
      send_pixel(make_pixel(128, 128, 128));
      send_pixel(make_pixel(1, 1, 1));
      send_pixel(make_pixel(255, 0, 0));
      send_pixel(make_pixel(200, 50, 50));
      send_pixel(make_pixel(0, 255, 0));
      send_pixel(make_pixel(0, 0, 255));
      send_pixel(make_pixel(255, 255, 0));
      send_pixel(make_pixel(0, 255, 255));
      send_pixel(make_pixel(255, 0, 255));
      send_pixel(make_pixel(255, 0, 1));
      send_pixel(make_pixel(255, 1, 0));
      send_pixel(make_pixel(255, 1, 1));
      send_pixel(make_pixel(128, 127, 127));
      send_pixel(make_pixel(128, 0, 0));
      send_pixel(make_pixel(1, 0, 0));
      send_pixel(make_pixel(0, 1, 0));
      send_pixel(make_pixel(0, 0, 1));
      send_pixel(make_pixel(255, 254, 254));
      send_pixel(make_pixel(254, 255, 255));
      send_pixel(make_pixel(170, 85, 0));
      send_pixel(make_pixel(0, 170, 255));
      drain_results();

      stream_pixels(0);
      stream_pixels(61);
      stream_pixels(0);
      stream_pixels(15);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
